[sv/pvd_pkg.sv]
// shared types, widths and the reversed varicode table for the varicode bit decoder
package pvd_pkg;

    // widths fixed by the item and result fields
    localparam int CHAR_W        = 7;
    localparam int CFG_W         = 16;
    localparam int COUNT_W       = 16;
    localparam int TABLE_ENTRIES = 128;
    localparam int ENTRY_W       = 10;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_START_GAP = 1'b0,
        REG_NO_LOCK   = 1'b1
    } cfg_index_t;

    // reversed varicode, lsb first, indexed by ascii code
    localparam logic [ENTRY_W-1:0] CODE_TABLE [TABLE_ENTRIES] = '{
        10'h355, 10'h36d, 10'h2dd, 10'h3bb, 10'h35d, 10'h3eb, 10'h3dd, 10'h2fd,
        10'h3fd, 10'h0f7, 10'h017, 10'h3db, 10'h2ed, 10'h01f, 10'h2bb, 10'h357,
        10'h3bd, 10'h2bd, 10'h2d7, 10'h3d7, 10'h36b, 10'h35b, 10'h2db, 10'h3ab,
        10'h37b, 10'h2fb, 10'h3b7, 10'h2ab, 10'h2eb, 10'h377, 10'h37d, 10'h3fb,
        10'h001, 10'h1ff, 10'h1f5, 10'h15f, 10'h1b7, 10'h2ad, 10'h375, 10'h1fd,
        10'h0df, 10'h0ef, 10'h1ed, 10'h1f7, 10'h057, 10'h02b, 10'h075, 10'h1eb,
        10'h0ed, 10'h0bd, 10'h0b7, 10'h0ff, 10'h1dd, 10'h1b5, 10'h1ad, 10'h16b,
        10'h1ab, 10'h1db, 10'h0af, 10'h17b, 10'h16f, 10'h055, 10'h1d7, 10'h3d5,
        10'h2f5, 10'h05f, 10'h0d7, 10'h0b5, 10'h0ad, 10'h077, 10'h0db, 10'h0bf,
        10'h155, 10'h07f, 10'h17f, 10'h17d, 10'h0eb, 10'h0dd, 10'h0bb, 10'h0d5,
        10'h0ab, 10'h177, 10'h0f5, 10'h07b, 10'h05b, 10'h1d5, 10'h15b, 10'h175,
        10'h15d, 10'h1bd, 10'h2d5, 10'h1df, 10'h1ef, 10'h1bf, 10'h3f5, 10'h16d,
        10'h3ed, 10'h00d, 10'h07d, 10'h03d, 10'h02d, 10'h003, 10'h02f, 10'h06d,
        10'h035, 10'h00b, 10'h1af, 10'h0fd, 10'h01b, 10'h037, 10'h00f, 10'h007,
        10'h03f, 10'h1fb, 10'h015, 10'h01d, 10'h005, 10'h03b, 10'h06f, 10'h06b,
        10'h0fb, 10'h05d, 10'h157, 10'h3b5, 10'h1bb, 10'h2b5, 10'h3ad, 10'h2b7
    };

endpackage

[sv/psk31_varicode_bit_decoder_unit.sv]
// psk31 varicode bit decoder: phase reversal timing, bit collection and table match
//
// Usage:
//   Input channel (item_valid / item_stall) carries one detector decision per item:
//   phase_flag (toggles on each 180 degree reversal) and bit_tick (symbol time elapsed).
//   Output channel (result_valid / result_stall) returns exactly one result per item:
//   ascii_char, char_valid, code_invalid and lock_status.
//   Config port (cfg_we, cfg_index, cfg_data) writes start_gap_count (index 0) and
//   no_lock_limit (index 1); write only while no item is in flight.
// Pipeline: an accepted item passes the input register, then the result register, before
//   result_valid. Throughput: one item per cycle while result_stall is low; all decoding
//   for an item is combinational, by the gap timer compare and a parallel 128-entry table match.
// Reset: all control state is cleared, the registers return to 16 and 1024, the decoder
//   is idle and unlocked, and both pipeline registers are empty.
// Stall: a stalled result holds in the result register while the input register still
//   advances into it when it drains; item_stall rises only when both registers are full
//   and result_stall is high.
module psk31_varicode_bit_decoder_unit #(
    parameter int CODE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input item channel
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       phase_flag,
    input  logic                       bit_tick,
    // result channel
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [pvd_pkg::CHAR_W-1:0] ascii_char,
    output logic                       char_valid,
    output logic                       code_invalid,
    output logic                       lock_status,
    // configuration writes
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [pvd_pkg::CFG_W-1:0]  cfg_data
);

    localparam int POS_W = $clog2(CODE_BITS + 1);
    localparam int IDX_W = $clog2(CODE_BITS);
    localparam int CW    = pvd_pkg::COUNT_W;

    // configuration registers
    logic [pvd_pkg::CFG_W-1:0] start_gap_reg;
    logic [pvd_pkg::CFG_W-1:0] no_lock_reg;

    // input register
    logic in_vld_reg;
    logic phase_reg;
    logic tick_reg;

    // decoder state
    logic                 frame_reg,  frame_next;
    logic                 prev_phase_reg;
    logic [CW-1:0]        gap_cnt_reg, gap_cnt_next;
    logic [CODE_BITS-1:0] acc_reg,    acc_next;
    logic [POS_W-1:0]     pos_reg,    pos_next;
    logic                 flip_reg,   flip_next;
    logic                 locked_reg, locked_next;

    // result register
    logic                       out_vld_reg;
    logic [pvd_pkg::CHAR_W-1:0] char_reg,   char_next;
    logic                       cvalid_reg, cvalid_next;
    logic                       bad_reg,    bad_next;

    logic advance;
    logic item_take;
    logic flip;
    logic gap;
    logic [CW-1:0] cnt_mid;
    logic found;
    logic [pvd_pkg::CHAR_W-1:0] found_idx;

    // handshake
    assign advance    = !out_vld_reg || !result_stall;
    assign item_stall = in_vld_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    // parallel table match, lowest index wins
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = pvd_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (acc_reg == CODE_BITS'(pvd_pkg::CODE_TABLE[i]))
            begin
                found     = 1'b1;
                found_idx = pvd_pkg::CHAR_W'(i);
            end
        end
    end

    // reversal timing and gap window
    assign flip    = phase_reg != prev_phase_reg;
    assign gap     = flip
                     && ({1'b0, gap_cnt_reg} + 17'd1 >= {1'b0, start_gap_reg})
                     && ({1'b0, gap_cnt_reg} <= {1'b0, start_gap_reg} + 17'd1);
    assign cnt_mid = flip ? '0 : gap_cnt_reg;

    // next state for the item in the input register
    always_comb
    begin
        frame_next  = frame_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        flip_next   = flip_reg || flip;
        locked_next = locked_reg;
        char_next   = '0;
        cvalid_next = 1'b0;
        bad_next    = 1'b0;

        // lock time-out
        if (cnt_mid > no_lock_reg)
        begin
            gap_cnt_next = '0;
            locked_next  = 1'b0;
        end
        else
        begin
            gap_cnt_next = cnt_mid + 1'b1;
        end

        if (gap)
        begin
            // character gap: decode what was collected and restart
            if (acc_reg != '0)
            begin
                if (found)
                begin
                    char_next   = found_idx;
                    cvalid_next = 1'b1;
                    locked_next = 1'b1;
                end
                else
                begin
                    bad_next    = 1'b1;
                    locked_next = 1'b0;
                end
            end
            frame_next = 1'b1;
            flip_next  = 1'b0;
            acc_next   = '0;
            pos_next   = '0;
        end
        else if (frame_reg && tick_reg)
        begin
            // one symbol: 1 when no reversal, 0 when a reversal was seen
            if (!(flip_reg || flip))
            begin
                if (pos_reg < POS_W'(CODE_BITS))
                begin
                    acc_next[pos_reg[IDX_W-1:0]] = 1'b1;
                end
            end
            else
            begin
                flip_next = 1'b0;
            end
            if (pos_reg < POS_W'(CODE_BITS))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_gap_reg <= 16'd16;
            no_lock_reg   <= 16'd1024;
        end
        else if (cfg_we)
        begin
            unique case (pvd_pkg::cfg_index_t'(cfg_index))
                pvd_pkg::REG_START_GAP: start_gap_reg <= cfg_data;
                pvd_pkg::REG_NO_LOCK:   no_lock_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_vld_reg <= item_take;
        end
        else if (item_take)
        begin
            in_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            phase_reg <= phase_flag;
            tick_reg  <= bit_tick;
        end
    end

    // decoder state, updated as an item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg      <= 1'b0;
            prev_phase_reg <= 1'b0;
            gap_cnt_reg    <= '0;
            acc_reg        <= '0;
            pos_reg        <= '0;
            flip_reg       <= 1'b0;
            locked_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg)
            begin
                frame_reg      <= frame_next;
                prev_phase_reg <= phase_reg;
                gap_cnt_reg    <= gap_cnt_next;
                acc_reg        <= acc_next;
                pos_reg        <= pos_next;
                flip_reg       <= flip_next;
                locked_reg     <= locked_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg)
        begin
            char_reg   <= char_next;
            cvalid_reg <= cvalid_next;
            bad_reg    <= bad_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign ascii_char   = char_reg;
    assign char_valid   = cvalid_reg;
    assign code_invalid = bad_reg;
    assign lock_status  = locked_reg;

endmodule

[sv/pvd_checker.sv]
// port-level checks for the varicode bit decoder, bound to the top level
module pvd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       result_valid,
    input logic                       result_stall,
    input logic [pvd_pkg::CHAR_W-1:0] ascii_char,
    input logic                       char_valid,
    input logic                       code_invalid,
    input logic                       lock_status
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a decode is either a character or a bad code, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(char_valid && code_invalid))
        else $error("char_valid and code_invalid together");

    // a bad code reports no character and drops lock
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && code_invalid |-> ascii_char == '0 && !lock_status)
        else $error("bad code with character or lock");

    // a good character always leaves the decoder locked
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && char_valid |-> lock_status)
        else $error("character decoded without lock");

endmodule

bind psk31_varicode_bit_decoder_unit pvd_checker u_pvd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ascii_char   (ascii_char),
    .char_valid   (char_valid),
    .code_invalid (code_invalid),
    .lock_status  (lock_status)
);
